### sv/area_average_image_downscaler_assert.svh
// Assertion macros for the area-average downscaler.
// Used by the top level only; depends on nothing else.
`ifndef AREA_AVERAGE_IMAGE_DOWNSCALER_ASSERT_SVH
`define AREA_AVERAGE_IMAGE_DOWNSCALER_ASSERT_SVH

`define ADS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`define ADS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### sv/ads_pkg.sv
// Shared types and constants of the area-average downscaler.
// Depends on nothing; every module and interface imports it.
package ads_pkg;

    localparam int DEF_MAX_SOURCE_DIM   = 4096;
    localparam int DEF_MAX_TARGET_WIDTH = 512;
    localparam int DEF_PIXEL_BITS       = 16;

    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int TW_REG_W   = 10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_W = 2'd0,
        CFG_SRC_H = 2'd1,
        CFG_TGT_W = 2'd2,
        CFG_TGT_H = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        DSEL_MEAN = 2'd0,
        DSEL_COL  = 2'd1,
        DSEL_ROW  = 2'd2
    } t_dsel;

    typedef struct packed {
        logic  accept;
        logic  resync;
        logic  rd;
        logic  acc;
        logic  div_start;
        t_dsel div_sel;
        logic  out_load;
    } t_cmd;

    typedef struct packed {
        logic need_sync;
        logic close;
        logic col_chg;
        logic row_chg;
        logic div_busy;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

### sv/ads_in_if.sv
// Source pixel channel of the downscaler: valid, ready and one RGB pixel.
// Depends on ads_pkg for the default pixel width.
interface ads_in_if import ads_pkg::*; #(
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
) ();
    logic                  valid;
    logic                  ready;
    logic                  start_of_frame;
    logic [PIXEL_BITS-1:0] red_in;
    logic [PIXEL_BITS-1:0] green_in;
    logic [PIXEL_BITS-1:0] blue_in;

    modport source (output valid, start_of_frame, red_in, green_in, blue_in, input ready);
    modport sink   (input valid, start_of_frame, red_in, green_in, blue_in, output ready);
endinterface

### sv/ads_out_if.sv
// Averaged pixel channel of the downscaler: valid, ready, RGB means and flags.
// Depends on ads_pkg for the default pixel width.
interface ads_out_if import ads_pkg::*; #(
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
) ();
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] red_avg;
    logic [PIXEL_BITS-1:0] green_avg;
    logic [PIXEL_BITS-1:0] blue_avg;
    logic                  row_end;
    logic                  frame_end;

    modport source (output valid, red_avg, green_avg, blue_avg, row_end, frame_end,
                     input ready);
    modport sink   (input valid, red_avg, green_avg, blue_avg, row_end, frame_end,
                    output ready);
endinterface

### sv/area_average_image_downscaler.sv
// Top level of the area-average downscaler: controller, datapath and checks.
// Depends on ads_pkg, ads_in_if, ads_out_if, ads_ctrl, ads_datapath and the assert header.
//
//   channel   direction  beat
//   i_pix     in         start_of_frame, red_in, green_in, blue_in
//   o_avg     out        red_avg, green_avg, blue_avg, row_end, frame_end
//   i_cfg_*   in         one register write per cycle with i_cfg_we high
//
// One source pixel is handled at a time: the next beat is taken only once the controller
// is back in S_IDLE after the read, sum update and any divisions of the previous one.
// A pixel closing a window adds one mean division and a load of the result; a new
// output column or row adds one edge division each, and a start of frame or new settings adds
// edge divisions for both column and row first. Reset is synchronous; there is no clearing pass.
// A result waits in the output register while the next beat is taken; a second one stalls.
module area_average_image_downscaler import ads_pkg::*; #(
    parameter int MAX_SOURCE_DIM   = DEF_MAX_SOURCE_DIM,
    parameter int MAX_TARGET_WIDTH = DEF_MAX_TARGET_WIDTH,
    parameter int PIXEL_BITS       = DEF_PIXEL_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    ads_in_if.sink                i_pix,
    ads_out_if.source             o_avg
);
    `include "area_average_image_downscaler_assert.svh"

    t_cmd w_cmd;
    t_sts w_sts;

    ads_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pix.valid),
        .o_in_ready (i_pix.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    ads_datapath #(
        .MAX_SOURCE_DIM   (MAX_SOURCE_DIM),
        .MAX_TARGET_WIDTH (MAX_TARGET_WIDTH),
        .PIXEL_BITS       (PIXEL_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_sof       (i_pix.start_of_frame),
        .i_red       (i_pix.red_in),
        .i_green     (i_pix.green_in),
        .i_blue      (i_pix.blue_in),
        .i_out_ready (o_avg.ready),
        .o_out_valid (o_avg.valid),
        .o_red       (o_avg.red_avg),
        .o_green     (o_avg.green_avg),
        .o_blue      (o_avg.blue_avg),
        .o_row_end   (o_avg.row_end),
        .o_frame_end (o_avg.frame_end),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts)
    );

    `ADS_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_pix.valid && i_pix.ready, !i_pix.ready, "pixel taken while the previous one is still at work")
    `ADS_ASSERT_SAME(a_out_slot_free, i_clk, i_rst_n, w_cmd.out_load, w_sts.out_free, "result loaded over an untaken one")
    `ADS_ASSERT_SAME(a_div_idle, i_clk, i_rst_n, w_cmd.div_start, !w_sts.div_busy, "divider started while busy")
endmodule

### sv/ads_divider.sv
// Restoring bit-serial divider with several lanes sharing one divisor.
// Depends on ads_pkg only by convention; one quotient bit per lane per cycle.
module ads_divider import ads_pkg::*; #(
    parameter int NUMW  = 42,
    parameter int DENW  = 25,
    parameter int LANES = 3
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [LANES-1:0][NUMW-1:0] i_numer,
    input  logic [DENW-1:0]            i_denom,
    output logic                       o_busy,
    output logic                       o_done,
    output logic [LANES-1:0][NUMW-1:0] o_quot
);
    localparam int CNTW = $clog2(NUMW + 1);

    logic [CNTW-1:0]                r_cnt;
    logic                           r_busy;
    logic                           r_done;
    logic [DENW-1:0]                r_den;
    logic [LANES-1:0][NUMW-1:0]     r_q;
    logic [LANES-1:0][DENW-1:0]     r_rem;
    logic [LANES-1:0][NUMW-1:0]     n_q;
    logic [LANES-1:0][DENW-1:0]     n_rem;

    always_comb begin
        logic [DENW:0] rem_sh;
        logic          ge;
        for (int l = 0; l < LANES; l++) begin
            rem_sh   = {r_rem[l], r_q[l][NUMW-1]};
            ge       = rem_sh >= {1'b0, r_den};
            n_rem[l] = ge ? DENW'(rem_sh - {1'b0, r_den}) : rem_sh[DENW-1:0];
            n_q[l]   = {r_q[l][NUMW-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(NUMW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNTW'(1);
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_numer;
            r_rem <= '0;
            r_den <= i_denom;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

### sv/ads_datapath.sv
// Datapath of the downscaler: registers, counters, column sum memory and output stage.
// Depends on ads_pkg and ads_divider; driven by commands from ads_ctrl.
module ads_datapath import ads_pkg::*; #(
    parameter int MAX_SOURCE_DIM   = DEF_MAX_SOURCE_DIM,
    parameter int MAX_TARGET_WIDTH = DEF_MAX_TARGET_WIDTH,
    parameter int PIXEL_BITS       = DEF_PIXEL_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_sof,
    input  logic [PIXEL_BITS-1:0] i_red,
    input  logic [PIXEL_BITS-1:0] i_green,
    input  logic [PIXEL_BITS-1:0] i_blue,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [PIXEL_BITS-1:0] o_red,
    output logic [PIXEL_BITS-1:0] o_green,
    output logic [PIXEL_BITS-1:0] o_blue,
    output logic                  o_row_end,
    output logic                  o_frame_end,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts
);
    localparam int DIMW  = $clog2(MAX_SOURCE_DIM + 1);
    localparam int CW    = $clog2(MAX_SOURCE_DIM);
    localparam int OCW   = (MAX_TARGET_WIDTH > 1) ? $clog2(MAX_TARGET_WIDTH) : 1;
    localparam int WW0   = (DIMW > CFG_DATA_W) ? DIMW : CFG_DATA_W;
    localparam int WW    = (WW0 > OCW + 1) ? WW0 : OCW + 1;
    localparam int AREAW = 2 * DIMW - 1;
    localparam int SUMW  = PIXEL_BITS + AREAW;
    localparam int NUMW  = SUMW + 1;

    logic [CFG_DATA_W-1:0] r_src_w, r_src_h, r_tgt_h;
    logic [TW_REG_W-1:0]   r_tgt_w;

    logic [CW-1:0]   r_sc, r_sr, r_or;
    logic [OCW-1:0]  r_oc;
    logic [DIMW-1:0] r_col_start, r_col_end, r_row_start, r_row_end;
    logic            r_col_chg, r_row_chg, r_stale, r_sof;
    logic [2:0][PIXEL_BITS-1:0] r_pix;
    logic [2:0][SUMW-1:0]       r_sum;
    logic [AREAW-1:0] r_area;
    logic             r_close, r_rend, r_fend;
    t_dsel            r_dsel;

    logic [2:0][SUMW-1:0] mem [MAX_TARGET_WIDTH];
    logic [2:0][SUMW-1:0] r_rd;

    logic                  r_ovalid;
    logic [2:0][PIXEL_BITS-1:0] r_oavg;
    logic                  r_orend, r_ofend;

    logic [DIMW-1:0] sw_e, sh_e, tw_e, th_e;
    logic [WW-1:0]   sw_raw, sh_raw, tw_raw, tw_m, th_raw;

    always_comb begin
        sw_raw = WW'(r_src_w);
        sh_raw = WW'(r_src_h);
        if (r_src_w == '0) begin
            sw_e = DIMW'(1);
        end else if (sw_raw > WW'(MAX_SOURCE_DIM)) begin
            sw_e = DIMW'(MAX_SOURCE_DIM);
        end else begin
            sw_e = DIMW'(sw_raw);
        end
        if (r_src_h == '0) begin
            sh_e = DIMW'(1);
        end else if (sh_raw > WW'(MAX_SOURCE_DIM)) begin
            sh_e = DIMW'(MAX_SOURCE_DIM);
        end else begin
            sh_e = DIMW'(sh_raw);
        end
        tw_raw = (r_tgt_w == '0) ? WW'(1) : WW'(r_tgt_w);
        tw_m   = (tw_raw > WW'(MAX_TARGET_WIDTH)) ? WW'(MAX_TARGET_WIDTH) : tw_raw;
        tw_e   = (tw_m > WW'(sw_e)) ? sw_e : DIMW'(tw_m);
        th_raw = (r_tgt_h == '0) ? WW'(1) : WW'(r_tgt_h);
        th_e   = (th_raw > WW'(sh_e)) ? sh_e : DIMW'(th_raw);
    end

    // Step of the counters for one accepted pixel.
    logic                 first, col_last, row_last, close;
    logic [2:0][SUMW-1:0] new_sum;
    logic [WW-1:0]        sc1, sr1, oc1, or1;
    logic [2*DIMW-1:0]    area_full;

    always_comb begin
        first    = (WW'(r_sr) == WW'(r_row_start)) && (WW'(r_sc) == WW'(r_col_start));
        col_last = (WW'(r_sc) + WW'(1)) >= WW'(r_col_end);
        row_last = (WW'(r_sr) + WW'(1)) >= WW'(r_row_end);
        close    = col_last && row_last;
        for (int k = 0; k < 3; k++) begin
            new_sum[k] = (first ? '0 : r_rd[k]) + SUMW'(r_pix[k]);
        end
        area_full = (r_col_end - r_col_start) * (r_row_end - r_row_start);
        oc1 = col_last ? WW'(r_oc) + WW'(1) : WW'(r_oc);
        sc1 = WW'(r_sc) + WW'(1);
        sr1 = WW'(r_sr);
        or1 = WW'(r_or);
        if (sc1 >= WW'(sw_e)) begin
            sc1 = '0;
            oc1 = '0;
            if (row_last) begin
                or1 = WW'(r_or) + WW'(1);
            end
            sr1 = WW'(r_sr) + WW'(1);
            if (sr1 >= WW'(sh_e)) begin
                sr1 = '0;
                or1 = '0;
            end
        end
        if (oc1 >= WW'(tw_e)) begin
            oc1 = '0;
        end
        if (or1 >= WW'(th_e)) begin
            or1 = '0;
        end
    end

    // Divider operands.
    logic                       div_busy, div_done;
    logic [2:0][NUMW-1:0]       div_numer, div_quot;
    logic [AREAW-1:0]           div_den;
    logic [2*WW-1:0]            edge_prod;

    always_comb begin
        edge_prod = '0;
        div_numer = '0;
        div_den   = r_area;
        case (i_cmd.div_sel)
            DSEL_COL: begin
                edge_prod    = (WW'(r_oc) + WW'(1)) * WW'(sw_e);
                div_numer[0] = NUMW'(edge_prod);
                div_den      = AREAW'(tw_e);
            end
            DSEL_ROW: begin
                edge_prod    = (WW'(r_or) + WW'(1)) * WW'(sh_e);
                div_numer[0] = NUMW'(edge_prod);
                div_den      = AREAW'(th_e);
            end
            default: begin
                for (int k = 0; k < 3; k++) begin
                    div_numer[k] = NUMW'(r_sum[k]) + NUMW'(r_area >> 1);
                end
            end
        endcase
    end

    ads_divider #(
        .NUMW  (NUMW),
        .DENW  (AREAW),
        .LANES (3)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_numer (div_numer),
        .i_denom (div_den),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd <= mem[r_oc];
        end
        if (i_cmd.acc) begin
            mem[r_oc] <= new_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pix <= {i_blue, i_green, i_red};
        end
        if (i_cmd.acc) begin
            r_sum  <= new_sum;
            r_area <= AREAW'(area_full);
            r_rend <= (WW'(r_oc) + WW'(1)) >= WW'(tw_e);
            r_fend <= ((WW'(r_oc) + WW'(1)) >= WW'(tw_e))
                      && ((WW'(r_or) + WW'(1)) >= WW'(th_e));
        end
        if (i_cmd.div_start) begin
            r_dsel <= i_cmd.div_sel;
        end
        if (i_cmd.out_load) begin
            for (int k = 0; k < 3; k++) begin
                r_oavg[k] <= div_quot[k][PIXEL_BITS-1:0];
            end
            r_orend <= r_rend;
            r_ofend <= r_fend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w     <= CFG_DATA_W'(1);
            r_src_h     <= CFG_DATA_W'(1);
            r_tgt_w     <= TW_REG_W'(1);
            r_tgt_h     <= CFG_DATA_W'(1);
            r_sc        <= '0;
            r_sr        <= '0;
            r_oc        <= '0;
            r_or        <= '0;
            r_col_start <= '0;
            r_row_start <= '0;
            r_col_end   <= DIMW'(1);
            r_row_end   <= DIMW'(1);
            r_col_chg   <= 1'b1;
            r_row_chg   <= 1'b1;
            r_stale     <= 1'b1;
            r_sof       <= 1'b0;
            r_close     <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_SRC_W: r_src_w <= i_cfg_data;
                    CFG_SRC_H: r_src_h <= i_cfg_data;
                    CFG_TGT_W: r_tgt_w <= i_cfg_data[TW_REG_W-1:0];
                    CFG_TGT_H: r_tgt_h <= i_cfg_data;
                    default:   r_tgt_h <= r_tgt_h;
                endcase
                r_stale <= 1'b1;
            end
            if (i_cfg_we || i_cmd.resync) begin
                r_sc        <= '0;
                r_sr        <= '0;
                r_oc        <= '0;
                r_or        <= '0;
                r_col_start <= '0;
                r_row_start <= '0;
                r_col_chg   <= 1'b1;
                r_row_chg   <= 1'b1;
            end
            if (i_cmd.resync) begin
                r_stale <= 1'b0;
            end
            if (i_cmd.accept) begin
                r_sof <= i_sof;
            end
            if (i_cmd.acc) begin
                r_close   <= close;
                r_sc      <= CW'(sc1);
                r_sr      <= CW'(sr1);
                r_oc      <= OCW'(oc1);
                r_or      <= CW'(or1);
                r_col_chg <= oc1 != WW'(r_oc);
                r_row_chg <= or1 != WW'(r_or);
                if (oc1 != WW'(r_oc)) begin
                    r_col_start <= (oc1 == '0) ? '0 : r_col_end;
                end
                if (or1 != WW'(r_or)) begin
                    r_row_start <= (or1 == '0) ? '0 : r_row_end;
                end
            end
            if (div_done) begin
                case (r_dsel)
                    DSEL_COL: begin
                        r_col_end <= DIMW'(div_quot[0]);
                        r_col_chg <= 1'b0;
                    end
                    DSEL_ROW: begin
                        r_row_end <= DIMW'(div_quot[0]);
                        r_row_chg <= 1'b0;
                    end
                    default: r_close <= r_close;
                endcase
            end
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_sts.need_sync = r_sof || r_stale;
    assign o_sts.close     = r_close;
    assign o_sts.col_chg   = r_col_chg;
    assign o_sts.row_chg   = r_row_chg;
    assign o_sts.div_busy  = div_busy;
    assign o_sts.div_done  = div_done;
    assign o_sts.out_free  = !r_ovalid || i_out_ready;

    assign o_out_valid = r_ovalid;
    assign o_red       = r_oavg[0];
    assign o_green     = r_oavg[1];
    assign o_blue      = r_oavg[2];
    assign o_row_end   = r_orend;
    assign o_frame_end = r_ofend;
endmodule

### sv/ads_ctrl.sv
// Controller of the downscaler: sequences one pixel through sum update, mean and window edges.
// Depends on ads_pkg; talks to ads_datapath through t_cmd and t_sts.
module ads_ctrl import ads_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_CHK   = 11'b00000000010,
        S_READ  = 11'b00000000100,
        S_ACC   = 11'b00000001000,
        S_MEAN  = 11'b00000010000,
        S_MWAIT = 11'b00000100000,
        S_OUT   = 11'b00001000000,
        S_COL   = 11'b00010000000,
        S_CWAIT = 11'b00100000000,
        S_ROW   = 11'b01000000000,
        S_RWAIT = 11'b10000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_pre, n_pre;

    always_comb begin
        n_state = r_state;
        n_pre   = r_pre;
        o_cmd   = '0;
        o_cmd.div_sel = DSEL_MEAN;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_CHK;
                end
            end
            S_CHK: begin
                if (i_sts.need_sync) begin
                    o_cmd.resync = 1'b1;
                    n_pre        = 1'b1;
                    n_state      = S_COL;
                end else begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = S_MEAN;
            end
            S_MEAN: begin
                if (i_sts.close) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_MWAIT;
                end else begin
                    n_state = S_COL;
                end
            end
            S_MWAIT: begin
                if (i_sts.div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_COL;
                end
            end
            S_COL: begin
                if (i_sts.col_chg) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DSEL_COL;
                    n_state         = S_CWAIT;
                end else begin
                    n_state = S_ROW;
                end
            end
            S_CWAIT: begin
                if (i_sts.div_done) begin
                    n_state = S_ROW;
                end
            end
            S_ROW: begin
                if (i_sts.row_chg) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DSEL_ROW;
                    n_state         = S_RWAIT;
                end else begin
                    n_pre   = 1'b0;
                    n_state = r_pre ? S_READ : S_IDLE;
                end
            end
            S_RWAIT: begin
                if (i_sts.div_done) begin
                    n_pre   = 1'b0;
                    n_state = r_pre ? S_READ : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_pre   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pre   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pre   <= n_pre;
        end
    end

    assign o_in_ready = r_state == S_IDLE;
endmodule
